// File: design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  // One free extent as it sits in a cell of the list.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } ext_t;

  localparam logic [31:0] ROUND_ADD  = 32'h0000_0fff;
  localparam logic [31:0] ROUND_MASK = 32'hffff_f000;
  localparam logic [31:0] SAT32      = 32'hffff_ffff;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage
`default_nettype wire

// File: design/ffa_cell.sv
`default_nettype none
module ffa_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire ffa_pkg::ext_t d_in,
  output ffa_pkg::ext_t      q
);
  import ffa_pkg::*;

  ext_t ext_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ext_r <= d_in;
    end
  end

  assign q = ext_r;

endmodule
`default_nettype wire

// File: design/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl #(
  parameter int MAX_EXTENTS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_op,
  input  wire logic [31:0]   in_block_addr,
  input  wire logic [31:0]   in_block_size,
  input  wire logic          in_round_4k,
  input  wire ffa_pkg::ext_t head,
  output ffa_pkg::ext_t      tail,
  output logic               shift_en,
  output logic               out_valid,
  output logic [31:0]        out_alloc_addr,
  output logic               out_status,
  output logic [31:0]        out_free_total,
  output logic [8:0]         out_entry_count,
  output logic [8:0]         out_peak_entries,
  output logic [31:0]        out_lost_count,
  output logic [31:0]        out_lost_bytes
);
  import ffa_pkg::*;

  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_EXTENTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PASS = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // How far the emitted stream trails the head of the ring.
  typedef enum logic [1:0] {
    LAG0 = 2'd0,
    LAG1 = 2'd1,
    LAG2 = 2'd2
  } lag_t;

  state_t        state_r, state_nxt;
  lag_t          lag_r, lag_nxt;
  logic [CW-1:0] t_r, t_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [31:0]   lost_cnt_r, lost_cnt_nxt;
  logic [31:0]   lost_bytes_r, lost_bytes_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic          done_r, done_nxt;
  logic          status_r, status_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic          op_r;
  logic [31:0]   addr_r;
  logic [31:0]   size_r;
  logic [32:0]   end_r;
  ext_t          p_r, p_nxt;
  ext_t          e_r, e_nxt;
  logic [31:0]   p_sum_r, p_sum_nxt;
  logic          p_touch_r, p_touch_nxt;

  logic          accept;
  logic [32:0]   rnd_sum;
  logic          rnd_ovf;
  logic [31:0]   rsize;
  logic          hval, yval, next_touch, prev_touch;
  logic [31:0]   new_len;
  ext_t          y;
  logic [CW+8:0] used_ext, peak_ext;

  assign accept  = start && (state_r == S_IDLE);
  assign rnd_sum = {1'b0, in_block_size} + {1'b0, ROUND_ADD};
  assign rnd_ovf = in_round_4k && rnd_sum[32];
  assign rsize   = in_round_4k ? (rnd_sum[31:0] & ROUND_MASK) : in_block_size;

  assign hval       = t_r < used_r;
  assign prev_touch = (t_r != '0) && p_touch_r;
  assign next_touch = hval && (end_r == {1'b0, head.start});
  assign new_len    = head.len - size_r;

  always_comb begin
    state_nxt      = state_r;
    lag_nxt        = lag_r;
    t_nxt          = t_r;
    used_nxt       = used_r;
    peak_nxt       = peak_r;
    lost_cnt_nxt   = lost_cnt_r;
    lost_bytes_nxt = lost_bytes_r;
    sum_nxt        = sum_r;
    done_nxt       = done_r;
    status_nxt     = status_r;
    res_addr_nxt   = res_addr_r;
    e_nxt          = e_r;
    shift_en       = 1'b0;
    y              = p_r;
    p_nxt          = head;

    case (lag_r)
      LAG0: y = head;
      LAG2: begin
        p_nxt = e_r;
        e_nxt = head;
      end
      default: ;
    endcase

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lag_nxt      = LAG1;
          t_nxt        = '0;
          sum_nxt      = '0;
          done_nxt     = 1'b0;
          res_addr_nxt = '0;
          status_nxt   = rnd_ovf ? ST_FAIL : ST_OK;
          if (rnd_ovf) begin
            sum_nxt   = sum_r;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PASS;
          end
        end
      end
      S_PASS: begin
        shift_en = 1'b1;
        if (!done_r && (op_r == OP_ALLOC) && hval && (head.len >= size_r)) begin
          done_nxt     = 1'b1;
          res_addr_nxt = head.start;
          if (new_len == '0) begin
            lag_nxt  = LAG0;
            used_nxt = used_r - 1'b1;
          end else begin
            p_nxt.start = head.start + size_r;
            p_nxt.len   = new_len;
          end
        end else if (!done_r && (op_r == OP_FREE) && (!hval || (head.start > addr_r))) begin
          done_nxt = 1'b1;
          if (prev_touch && next_touch) begin
            y.len    = sat_add(p_sum_r, head.len);
            lag_nxt  = LAG0;
            used_nxt = used_r - 1'b1;
          end else if (prev_touch) begin
            y.len = p_sum_r;
          end else if (next_touch) begin
            p_nxt.start = addr_r;
            p_nxt.len   = sat_add(head.len, size_r);
          end else if (used_r != LAST) begin
            p_nxt.start = addr_r;
            p_nxt.len   = size_r;
            e_nxt       = head;
            lag_nxt     = LAG2;
            used_nxt    = used_r + 1'b1;
            if (peak_r < used_nxt) begin
              peak_nxt = used_nxt;
            end
          end else begin
            status_nxt     = ST_FAIL;
            lost_cnt_nxt   = sat_add(lost_cnt_r, 32'd1);
            lost_bytes_nxt = sat_add(lost_bytes_r, size_r);
          end
        end
        if (yval) begin
          sum_nxt = sat_add(sum_r, y.len);
        end
        t_nxt = t_r + 1'b1;
        if (t_r == LAST) begin
          state_nxt = S_DONE;
          // A free into a full list can still resolve on this last step.
          if (!done_nxt) begin
            status_nxt = ST_FAIL;
          end
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // The emitted word at step t becomes list entry t-1 once the ring is realigned.
  assign yval = (t_r != '0) && (t_r <= used_r);

  assign p_sum_nxt   = sat_add(p_nxt.len, size_r);
  assign p_touch_nxt = ({1'b0, p_nxt.start} + {1'b0, p_nxt.len}) == {1'b0, addr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      peak_r       <= '0;
      lost_cnt_r   <= '0;
      lost_bytes_r <= '0;
      sum_r        <= '0;
      lag_r        <= LAG1;
      t_r          <= '0;
      done_r       <= 1'b0;
      status_r     <= ST_OK;
      res_addr_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      peak_r       <= peak_nxt;
      lost_cnt_r   <= lost_cnt_nxt;
      lost_bytes_r <= lost_bytes_nxt;
      sum_r        <= sum_nxt;
      lag_r        <= lag_nxt;
      t_r          <= t_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
      res_addr_r   <= res_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      addr_r <= in_block_addr;
      size_r <= rsize;
      end_r  <= {1'b0, in_block_addr} + {1'b0, rsize};
    end
    if (state_r == S_PASS) begin
      p_r       <= p_nxt;
      e_r       <= e_nxt;
      p_sum_r   <= p_sum_nxt;
      p_touch_r <= p_touch_nxt;
    end
  end

  assign used_ext = {9'd0, used_r};
  assign peak_ext = {9'd0, peak_r};

  assign busy             = (state_r != S_IDLE);
  assign tail             = y;
  assign out_valid        = (state_r == S_DONE);
  assign out_alloc_addr   = res_addr_r;
  assign out_status       = status_r;
  assign out_free_total   = sum_r;
  assign out_entry_count  = used_ext[8:0];
  assign out_peak_entries = peak_ext[8:0];
  assign out_lost_count   = lost_cnt_r;
  assign out_lost_bytes   = lost_bytes_r;

endmodule
`default_nettype wire

// File: design/first_fit_free_list_allocator_top.sv
// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------------
// request   | start, busy          | in_op, in_block_addr, in_block_size, in_round_4k
// result    | out_valid (strobe)   | out_alloc_addr, out_status, out_free_total,
//           |                      | out_entry_count, out_peak_entries,
//           |                      | out_lost_count, out_lost_bytes
//
// A request is taken when start is high while busy is low.
// Each item makes a pass (S_PASS), one full rotation of the ring of extent cells,
// then shows its result in S_DONE; a size whose 4 KiB round-up overflows is refused
// without a pass and goes from idle straight to S_DONE.
// Reset (rst_n low, synchronous) empties the list and clears all counters.
// The result is shown for one cycle only; the receiver cannot stall it.
`default_nettype none
module first_fit_free_list_allocator_top #(
  parameter int MAX_EXTENTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [31:0] in_block_addr,
  input  wire logic [31:0] in_block_size,
  input  wire logic        in_round_4k,
  output logic             out_valid,
  output logic [31:0]      out_alloc_addr,
  output logic             out_status,
  output logic [31:0]      out_free_total,
  output logic [8:0]       out_entry_count,
  output logic [8:0]       out_peak_entries,
  output logic [31:0]      out_lost_count,
  output logic [31:0]      out_lost_bytes
);
  import ffa_pkg::*;

  // The extents live in a row of cells that shifts toward cell 0 on every
  // cycle of a pass. The controller reads the head, rewrites the stream
  // (carving, merging, inserting or removing one extent) and feeds the tail,
  // so after a full rotation the updated list sits sorted from cell 0 again.
  ext_t cell_q [MAX_EXTENTS];
  ext_t head;
  ext_t tail;
  logic shift_en;

  assign head = cell_q[0];

  for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
    ext_t d;
    if (i == MAX_EXTENTS - 1) begin : g_tail
      assign d = tail;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    ffa_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d),
      .q        (cell_q[i])
    );
  end

  // The controller keeps zero, one or two extents in flight so that an insertion
  // or a removal simply changes the lag between the head and the tail.
  ffa_ctrl #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_block_addr    (in_block_addr),
    .in_block_size    (in_block_size),
    .in_round_4k      (in_round_4k),
    .head             (head),
    .tail             (tail),
    .shift_en         (shift_en),
    .out_valid        (out_valid),
    .out_alloc_addr   (out_alloc_addr),
    .out_status       (out_status),
    .out_free_total   (out_free_total),
    .out_entry_count  (out_entry_count),
    .out_peak_entries (out_peak_entries),
    .out_lost_count   (out_lost_count),
    .out_lost_bytes   (out_lost_bytes)
  );

endmodule
`default_nettype wire

// File: design/ffa_checker.sv
`default_nettype none
module ffa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_status,
  input wire logic [31:0] out_alloc_addr
);

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle or block stayed busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !out_valid)
    else $error("result shown while idle");

  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_alloc_addr != 32'd0) |-> !out_status)
    else $error("nonzero address reported with a failure status");

endmodule

bind first_fit_free_list_allocator_top ffa_checker u_ffa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_alloc_addr (out_alloc_addr)
);
`default_nettype wire
